// ===== src/heater_pwm_cycle_with_safety_timeout_top_assert.svh =====
// Assertion macros for the heater drive period generator.
// Included by the RTL files that carry concurrent checks; no other dependencies.
`ifndef HEATER_PWM_CYCLE_WITH_SAFETY_TIMEOUT_TOP_ASSERT_SVH
`define HEATER_PWM_CYCLE_WITH_SAFETY_TIMEOUT_TOP_ASSERT_SVH

`ifndef NO_ASSERTIONS
// Checked property, disabled while reset is high
`define HPWM_ASSERT(lbl, clk_s, rst_s, prop) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) prop) \
    else $error("heater pwm assertion failed");
// Checked property, also checked during reset
`define HPWM_ASSERT_ALWAYS(lbl, clk_s, prop) \
  lbl: assert property (@(posedge clk_s) prop) \
    else $error("heater pwm assertion failed");
`else
`define HPWM_ASSERT(lbl, clk_s, rst_s, prop)
`define HPWM_ASSERT_ALWAYS(lbl, clk_s, prop)
`endif

`endif

// ===== src/hpwm_pkg.sv =====
// Shared types and constants for the heater drive period generator.
// No dependencies; used by every RTL file of the block.
`default_nettype none

package hpwm_pkg;

  // Item kinds on the input channel
  typedef enum logic {
    OP_TICK      = 1'b0,
    OP_SET_DRIVE = 1'b1
  } opcode_t;

  // Configuration register indexes
  localparam int unsigned REG_POWER_WINDOW = 0;

  localparam logic [7:0] POWER_WINDOW_RESET = 8'd255;

  // Prescaler limits per mode
  localparam logic [4:0] FAST_PRESCALE = 5'd10;
  localparam logic [4:0] SLOW_PRESCALE = 5'd20;

  // Holdoff and measure counts per mode
  localparam logic [8:0] FAST_HOLDOFF = 9'd20;
  localparam logic [8:0] FAST_MEASURE = 9'd10;
  localparam logic [8:0] SLOW_HOLDOFF = 9'd10;
  localparam logic [8:0] SLOW_MEASURE = 9'd5;

  localparam logic [3:0] SAFETY_RELOAD = 4'd10;

  // Longest period: full power window plus fast holdoff and measure
  localparam logic [8:0] PERIOD_MAX = 9'd255 + FAST_HOLDOFF + FAST_MEASURE;

  // One result item; first member sits in the top bits
  typedef struct packed {
    logic [3:0] safety_left;
    logic       fast_active;
    logic       period_start;
    logic       sample_window;
    logic       drive_on;
  } result_t;

endpackage

`default_nettype wire

// ===== src/hpwm_core.sv =====
// Period timer, safety counter and drive decision for one item per cycle while step is high.
// Depends on hpwm_pkg and the assertion macro header.
`default_nettype none

`include "heater_pwm_cycle_with_safety_timeout_top_assert.svh"

module hpwm_core (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                step,
  input  wire hpwm_pkg::opcode_t   opcode,
  input  wire logic [7:0]          pulse_length,
  input  wire logic                want_fast,
  input  wire logic [7:0]          power_window,
  output hpwm_pkg::result_t        result
);

  logic [4:0] prescale_count, prescale_count_next;
  logic [8:0] period_count, period_count_next;
  logic [3:0] safety_count, safety_count_next;
  logic [7:0] pending_pulse, pending_pulse_next;
  logic       pending_fast, pending_fast_next;
  logic       mode_fast, mode_fast_next;
  logic [7:0] pulse_end, pulse_end_next;
  logic       drive_enabled, drive_enabled_next;
  logic       started;

  logic [4:0] limit;
  logic [8:0] period_len;
  logic [8:0] sample_from;

  // Prescaler limit and live period length for the current mode
  always_comb begin
    limit      = mode_fast ? hpwm_pkg::FAST_PRESCALE : hpwm_pkg::SLOW_PRESCALE;
    period_len = {1'b0, power_window} + (mode_fast ?
                 (hpwm_pkg::FAST_HOLDOFF + hpwm_pkg::FAST_MEASURE) :
                 (hpwm_pkg::SLOW_HOLDOFF + hpwm_pkg::SLOW_MEASURE));
  end

  // Next state for the item in the input register
  always_comb begin
    prescale_count_next = prescale_count;
    period_count_next   = period_count;
    safety_count_next   = safety_count;
    pending_pulse_next  = pending_pulse;
    pending_fast_next   = pending_fast;
    mode_fast_next      = mode_fast;
    pulse_end_next      = pulse_end;
    drive_enabled_next  = drive_enabled;
    started             = 1'b0;
    unique case (opcode)
      hpwm_pkg::OP_SET_DRIVE: begin
        safety_count_next  = hpwm_pkg::SAFETY_RELOAD;
        pending_pulse_next = pulse_length;
        pending_fast_next  = want_fast;
      end
      hpwm_pkg::OP_TICK: begin
        if ({1'b0, prescale_count} + 6'd1 >= {1'b0, limit}) begin
          prescale_count_next = '0;
          if (period_count >= period_len) begin
            // period end: apply pending request while safety time remains
            started           = 1'b1;
            period_count_next = '0;
            if (safety_count != 4'd0) begin
              safety_count_next = safety_count - 4'd1;
              mode_fast_next    = pending_fast;
              if (pending_pulse != 8'd0) begin
                pulse_end_next     = pending_pulse - 8'd1;
                drive_enabled_next = 1'b1;
              end else begin
                drive_enabled_next = 1'b0;
              end
            end else begin
              drive_enabled_next = 1'b0;
            end
          end else begin
            period_count_next = period_count + 9'd1;
          end
        end else begin
          prescale_count_next = prescale_count + 5'd1;
        end
      end
      default: begin
      end
    endcase
  end

  // Result from the updated state
  always_comb begin
    sample_from = {1'b0, power_window} +
                  (mode_fast_next ? hpwm_pkg::FAST_HOLDOFF : hpwm_pkg::SLOW_HOLDOFF);
    result.drive_on      = drive_enabled_next && (period_count_next < {1'b0, pulse_end_next});
    result.sample_window = period_count_next >= sample_from;
    result.period_start  = started;
    result.fast_active   = mode_fast_next;
    result.safety_left   = safety_count_next;
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      prescale_count <= '0;
      period_count   <= '0;
      safety_count   <= '0;
      pending_pulse  <= '0;
      pending_fast   <= 1'b0;
      mode_fast      <= 1'b0;
      pulse_end      <= '0;
      drive_enabled  <= 1'b0;
    end else if (step) begin
      prescale_count <= prescale_count_next;
      period_count   <= period_count_next;
      safety_count   <= safety_count_next;
      pending_pulse  <= pending_pulse_next;
      pending_fast   <= pending_fast_next;
      mode_fast      <= mode_fast_next;
      pulse_end      <= pulse_end_next;
      drive_enabled  <= drive_enabled_next;
    end
  end

  `HPWM_ASSERT(a_safety_range, clk, rst, safety_count <= hpwm_pkg::SAFETY_RELOAD)
  `HPWM_ASSERT(a_period_range, clk, rst, period_count <= hpwm_pkg::PERIOD_MAX)
  `HPWM_ASSERT(a_start_clears, clk, rst, (step && started) |=> (period_count == 9'd0))
  `HPWM_ASSERT(a_drive_needs_enable, clk, rst, (step && result.drive_on) |=> drive_enabled)

endmodule

`default_nettype wire

// ===== src/hpwm_ostage.sv =====
// Output register for result items, held until the downstream side takes them.
// Depends on hpwm_pkg.
`default_nettype none

module hpwm_ostage (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              load,
  input  wire hpwm_pkg::result_t result,
  output logic                   busy,
  output logic                   m_tvalid,
  input  wire logic              m_tready,
  output logic [7:0]             m_tdata    // drive_on, sample_window, period_start,
                                            // fast_active, safety_left[3:0]
);

  hpwm_pkg::result_t held;

  // Full and not being drained this cycle
  assign busy    = m_tvalid && !m_tready;
  assign m_tdata = held;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held <= result;
    end
  end

endmodule

`default_nettype wire

// ===== src/heater_pwm_cycle_with_safety_timeout_top.sv =====
// Heater drive period generator with safety timeout: top level.
// Depends on hpwm_pkg, hpwm_core and hpwm_ostage.
//
//  channel  | direction | handshake            | contents
//  s_*      | in        | s_tvalid / s_tready  | tick or set-drive item
//  m_*      | out       | m_tvalid / m_tready  | one result item per input item
//  apb      | in        | psel, penable, pready| power_window when paddr[2] is 0
//
// One item per cycle sustained while the output is not stalled; an item waits in the input register
// and its result is then loaded into the output register.
// The state update and result logic sit between those two registers.
// Synchronous active-high reset clears the timer state and sets power_window to 255.
// A stalled output holds its result; the input register keeps taking items while
// the output is free or being drained in the same cycle.
`default_nettype none

module heater_pwm_cycle_with_safety_timeout_top (
  input  wire logic        clk,
  input  wire logic        rst,
  // input stream
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [15:0] s_tdata,   // pulse_length[7:0], want_fast, zero fill
  input  wire logic        s_tuser,   // opcode
  // result stream
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [7:0]       m_tdata,   // drive_on, sample_window, period_start,
                                      // fast_active, safety_left[3:0]
  // configuration
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  logic [7:0]        power_window;
  logic              ivalid;
  hpwm_pkg::opcode_t iopcode;
  logic [7:0]        ipulse;
  logic              ifast;
  logic              move;
  logic              obusy;
  hpwm_pkg::result_t result;

  // Configuration register
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      power_window <= hpwm_pkg::POWER_WINDOW_RESET;
    end else if (psel && penable && pwrite && pready &&
                 (paddr[2] == 1'(hpwm_pkg::REG_POWER_WINDOW))) begin
      power_window <= pwdata[7:0];
    end
  end

  always_comb begin
    if (paddr[2] == 1'(hpwm_pkg::REG_POWER_WINDOW)) begin
      prdata = {24'd0, power_window};
    end else begin
      prdata = '0;
    end
  end

  // Input register
  assign move     = ivalid && !obusy;
  assign s_tready = !ivalid || move;

  always_ff @(posedge clk) begin
    if (rst) begin
      ivalid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      ivalid <= 1'b1;
    end else if (move) begin
      ivalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      iopcode <= hpwm_pkg::opcode_t'(s_tuser);
      ipulse  <= s_tdata[7:0];
      ifast   <= s_tdata[8];
    end
  end

  hpwm_core u_core (
    .clk          (clk),
    .rst          (rst),
    .step         (move),
    .opcode       (iopcode),
    .pulse_length (ipulse),
    .want_fast    (ifast),
    .power_window (power_window),
    .result       (result)
  );

  hpwm_ostage u_ostage (
    .clk      (clk),
    .rst      (rst),
    .load     (move),
    .result   (result),
    .busy     (obusy),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule

`default_nettype wire
